>>> sv/transport_checksum_generator_unit_defines.svh
// ----------------------------------------------------------------------------
// Transport checksum generator assertion macros
// Shared concurrent assertion forms for the checksum generator.
// ----------------------------------------------------------------------------
`ifndef TRANSPORT_CHECKSUM_GENERATOR_UNIT_DEFINES_SVH
`define TRANSPORT_CHECKSUM_GENERATOR_UNIT_DEFINES_SVH

// same-cycle implication
`define TCG_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tcg assertion failed: same-cycle implication");

// next-cycle implication
`define TCG_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tcg assertion failed: next-cycle implication");

`endif

>>> sv/tcg_pkg.sv
// ----------------------------------------------------------------------------
// Transport checksum generator package
// Transaction types, register indexes and checksum helpers.
// ----------------------------------------------------------------------------
package tcg_pkg;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 64;

   localparam logic [CSR_IDX_W-1:0] CSR_MODE     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SRC_HIGH = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SRC_LOW  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DST_HIGH = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DST_LOW  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_PWF      = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_SEQ_ACK  = 3'd6;

   localparam logic [15:0] UDP_HDR_LEN      = 16'd8;
   localparam logic [15:0] TCP_HDR_LEN      = 16'd20;
   localparam logic [15:0] PROTO_UDP        = 16'd17;
   localparam logic [15:0] PROTO_TCP        = 16'd6;
   localparam logic [15:0] TCP_OFFSET_WORD  = 16'h5000;
   localparam logic [15:0] ZERO_REPLACEMENT = 16'hFFFF;

   typedef struct packed {
      logic [7:0] payload_byte;
      logic       has_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [15:0] checksum;
      logic [15:0] transport_length;
   } rsp_type;

   typedef struct packed {
      logic [1:0]  mode;
      logic [63:0] source_address_high;
      logic [63:0] source_address_low;
      logic [63:0] dest_address_high;
      logic [63:0] dest_address_low;
      logic [55:0] port_window_flags;
      logic [63:0] tcp_sequence_ack;
   } cfg_type;

   // payload totals of one packet, handed from front to back
   typedef struct packed {
      logic [16:0] sum;
      logic [15:0] count;
   } mid_type;

   function automatic logic [16:0] oc_add(input logic [16:0] s, input logic [15:0] w);
      logic [17:0] t;
      t = {1'b0, s} + {2'b00, w};
      return {1'b0, t[15:0]} + {15'd0, t[17:16]};
   endfunction

   function automatic logic [17:0] sum4(input logic [63:0] v);
      return {2'b00, v[63:48]} + {2'b00, v[47:32]} + {2'b00, v[31:16]} + {2'b00, v[15:0]};
   endfunction

endpackage

>>> sv/tcg_fifo.sv
// ----------------------------------------------------------------------------
// Transport checksum generator queue
// Small register-based FIFO with first-word fall-through read.
// ----------------------------------------------------------------------------
module tcg_fifo #(
   parameter int WIDTH = 33,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty,
   output logic             full
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign empty   = (count_ff == '0);
   assign full    = (count_ff == FULL_CNT);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

>>> sv/tcg_front.sv
// ----------------------------------------------------------------------------
// Transport checksum generator front end
// Pairs payload bytes into words and keeps the running payload sum.
// ----------------------------------------------------------------------------
module tcg_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  tcg_pkg::req_type req_payload,
   output logic             mid_push,
   output tcg_pkg::mid_type mid_data
);

   logic [16:0] sum_ff, sum_in;
   logic [15:0] count_ff, count_in;
   logic [7:0]  held_ff, held_in;
   logic        odd_ff, odd_in;

   logic [7:0]  byte_val;
   logic [15:0] word;
   logic [16:0] sum_add;
   logic [15:0] count_next;
   logic        add_en;

   always_comb begin
      byte_val   = req_payload.has_byte ? req_payload.payload_byte : 8'h00;
      word       = odd_ff ? {held_ff, byte_val} : {byte_val, 8'h00};
      sum_add    = tcg_pkg::oc_add(sum_ff, word);
      count_next = count_ff + {15'd0, req_payload.has_byte};
      add_en     = req_payload.last_byte ? (odd_ff || req_payload.has_byte)
                                         : (odd_ff && req_payload.has_byte);

      mid_push       = accept && req_payload.last_byte;
      mid_data.sum   = add_en ? sum_add : sum_ff;
      mid_data.count = count_next;

      sum_in   = sum_ff;
      count_in = count_ff;
      held_in  = held_ff;
      odd_in   = odd_ff;
      if (accept) begin
         if (req_payload.last_byte) begin
            sum_in   = '0;
            count_in = '0;
            held_in  = '0;
            odd_in   = 1'b0;
         end else if (req_payload.has_byte) begin
            count_in = count_next;
            if (odd_ff) begin
               sum_in = sum_add;
               odd_in = 1'b0;
            end else begin
               held_in = req_payload.payload_byte;
               odd_in  = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff   <= '0;
         count_ff <= '0;
         held_ff  <= '0;
         odd_ff   <= 1'b0;
      end else begin
         sum_ff   <= sum_in;
         count_ff <= count_in;
         held_ff  <= held_in;
         odd_ff   <= odd_in;
      end
   end

endmodule

>>> sv/tcg_back.sv
// ----------------------------------------------------------------------------
// Transport checksum generator back end
// Adds pseudo-header and transport header, folds, complements, queues result.
// ----------------------------------------------------------------------------
module tcg_back #(
   parameter int RSP_DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  tcg_pkg::cfg_type cfg,
   input  logic             mid_empty,
   input  tcg_pkg::mid_type mid_data,
   output logic             mid_pop,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output tcg_pkg::rsp_type rsp_data
);

   localparam int OW = $clog2(RSP_DEPTH + 1);
   localparam logic [OW-1:0] CREDITS = OW'(RSP_DEPTH);

   logic [OW-1:0] outstanding_ff, outstanding_in;
   logic          issue, rsp_accept, rsp_full;

   logic        v6, tcp;
   logic [15:0] len;
   logic [17:0] a_src_hi, a_src_lo, a_dst_hi, a_dst_lo;
   logic [18:0] a_tcp, a_misc;

   logic        v1_ff;
   logic [17:0] s_src_hi_ff, s_src_lo_ff, s_dst_hi_ff, s_dst_lo_ff;
   logic [18:0] s_tcp_ff, s_misc_ff;
   logic [15:0] len1_ff;
   logic        v6udp1_ff;

   logic [21:0] total;
   logic [16:0] fold1;
   logic        v2_ff;
   logic [16:0] fold_ff;
   logic [15:0] len2_ff;
   logic        v6udp2_ff;

   logic [15:0]      folded, ck;
   tcg_pkg::rsp_type rsp_wdata;

   assign issue      = !mid_empty && (outstanding_ff < CREDITS);
   assign mid_pop    = issue;
   assign rsp_accept = rsp_pop && !rsp_empty;

   always_comb begin
      outstanding_in = outstanding_ff;
      if (issue && !rsp_accept) begin
         outstanding_in = outstanding_ff + 1'b1;
      end else if (rsp_accept && !issue) begin
         outstanding_in = outstanding_ff - 1'b1;
      end
   end

   always_comb begin
      v6  = cfg.mode[0];
      tcp = cfg.mode[1];
      len = mid_data.count + (tcp ? tcg_pkg::TCP_HDR_LEN : tcg_pkg::UDP_HDR_LEN);

      a_src_hi = v6 ? tcg_pkg::sum4(cfg.source_address_high) : '0;
      a_dst_hi = v6 ? tcg_pkg::sum4(cfg.dest_address_high) : '0;
      a_src_lo = v6 ? tcg_pkg::sum4(cfg.source_address_low)
                    : {2'b00, cfg.source_address_low[31:16]}
                      + {2'b00, cfg.source_address_low[15:0]};
      a_dst_lo = v6 ? tcg_pkg::sum4(cfg.dest_address_low)
                    : {2'b00, cfg.dest_address_low[31:16]}
                      + {2'b00, cfg.dest_address_low[15:0]};

      if (tcp) begin
         a_tcp = {1'b0, tcg_pkg::sum4(cfg.tcp_sequence_ack)}
                 + {3'b000, tcg_pkg::TCP_OFFSET_WORD | {10'd0, cfg.port_window_flags[5:0]}}
                 + {3'b000, cfg.port_window_flags[23:8]};
      end else begin
         a_tcp = {3'b000, len};
      end

      a_misc = {3'b000, cfg.port_window_flags[55:40]}
               + {3'b000, cfg.port_window_flags[39:24]}
               + {3'b000, tcp ? tcg_pkg::PROTO_TCP : tcg_pkg::PROTO_UDP}
               + {3'b000, len}
               + {2'b00, mid_data.sum};
   end

   always_comb begin
      total = 22'(s_src_hi_ff) + 22'(s_src_lo_ff) + 22'(s_dst_hi_ff)
              + 22'(s_dst_lo_ff) + 22'(s_tcp_ff) + 22'(s_misc_ff);
      fold1 = {1'b0, total[15:0]} + {11'd0, total[21:16]};

      folded = fold_ff[15:0] + {15'd0, fold_ff[16]};
      ck     = ~folded;
      rsp_wdata.checksum         = (v6udp2_ff && (ck == 16'h0000))
                                   ? tcg_pkg::ZERO_REPLACEMENT : ck;
      rsp_wdata.transport_length = len2_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         outstanding_ff <= '0;
         v1_ff          <= 1'b0;
         v2_ff          <= 1'b0;
      end else begin
         outstanding_ff <= outstanding_in;
         v1_ff          <= issue;
         v2_ff          <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      s_src_hi_ff <= a_src_hi;
      s_src_lo_ff <= a_src_lo;
      s_dst_hi_ff <= a_dst_hi;
      s_dst_lo_ff <= a_dst_lo;
      s_tcp_ff    <= a_tcp;
      s_misc_ff   <= a_misc;
      len1_ff     <= len;
      v6udp1_ff   <= v6 && !tcp;
      fold_ff     <= fold1;
      len2_ff     <= len1_ff;
      v6udp2_ff   <= v6udp1_ff;
   end

   tcg_fifo #(
      .WIDTH ($bits(tcg_pkg::rsp_type)),
      .DEPTH (RSP_DEPTH)
   ) u_rsp_queue (
      .clock (clock),
      .reset (reset),
      .push  (v2_ff),
      .wdata (rsp_wdata),
      .pop   (rsp_pop),
      .rdata (rsp_data),
      .empty (rsp_empty),
      .full  (rsp_full)
   );

   // the credit count keeps the result queue from overflowing
   logic unused_full;
   assign unused_full = rsp_full;

endmodule

>>> sv/transport_checksum_generator_unit.sv
// ----------------------------------------------------------------------------
// Transport checksum generator
// TCP/UDP checksum over payload bytes plus pseudo-header and transport header.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue: drive req_payload and raise req_push; a byte is taken at a
//   clock edge where req_push is high and req_full is low. One byte per
//   transaction, last_byte closes the packet (has_byte low for an empty one).
//   Result queue: while rsp_empty is low, rsp_payload holds the oldest
//   checksum and transport length; rsp_pop takes it.
//   Configuration: csr_we, csr_index and csr_wdata write one register per
//   cycle; write only while no packet is in flight.
// Timing:
//   One byte per cycle while req_full is low. A closing transaction reaches the
//   result queue through the front sum into the packet queue, header sums and
//   fold/complement. The back end pipeline holds at most RSP_DEPTH packets
//   counting its result queue; further closing bytes wait in the packet queue
//   and req_full rises once it fills, so a stalled receiver backs up input.
// Reset:
//   Clears the configuration registers, the pipeline valid flags, the running sum and both queues.
// ----------------------------------------------------------------------------
`include "transport_checksum_generator_unit_defines.svh"

module transport_checksum_generator_unit #(
   parameter int MID_DEPTH = 2,
   parameter int RSP_DEPTH = 4
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_push,
   output logic                                req_full,
   input  tcg_pkg::req_type                    req_payload,
   output logic                                rsp_empty,
   input  logic                                rsp_pop,
   output tcg_pkg::rsp_type                    rsp_payload,
   input  logic                                csr_we,
   input  logic [tcg_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [tcg_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   tcg_pkg::cfg_type cfg_ff, cfg_in;
   tcg_pkg::mid_type mid_wdata, mid_rdata;
   logic             req_accept;
   logic             mid_push, mid_pop, mid_empty, mid_full;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            tcg_pkg::CSR_MODE:     cfg_in.mode                = csr_wdata[1:0];
            tcg_pkg::CSR_SRC_HIGH: cfg_in.source_address_high = csr_wdata;
            tcg_pkg::CSR_SRC_LOW:  cfg_in.source_address_low  = csr_wdata;
            tcg_pkg::CSR_DST_HIGH: cfg_in.dest_address_high   = csr_wdata;
            tcg_pkg::CSR_DST_LOW:  cfg_in.dest_address_low    = csr_wdata;
            tcg_pkg::CSR_PWF:      cfg_in.port_window_flags   = csr_wdata[55:0];
            tcg_pkg::CSR_SEQ_ACK:  cfg_in.tcp_sequence_ack    = csr_wdata;
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_full   = mid_full;
   assign req_accept = req_push && !mid_full;

   tcg_front u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (req_accept),
      .req_payload (req_payload),
      .mid_push    (mid_push),
      .mid_data    (mid_wdata)
   );

   tcg_fifo #(
      .WIDTH ($bits(tcg_pkg::mid_type)),
      .DEPTH (MID_DEPTH)
   ) u_mid_queue (
      .clock (clock),
      .reset (reset),
      .push  (mid_push),
      .wdata (mid_wdata),
      .pop   (mid_pop),
      .rdata (mid_rdata),
      .empty (mid_empty),
      .full  (mid_full)
   );

   tcg_back #(
      .RSP_DEPTH (RSP_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .mid_empty (mid_empty),
      .mid_data  (mid_rdata),
      .mid_pop   (mid_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_payload)
   );

   `TCG_ASSERT_NEXT(a_reset_clears, clock, 1'b0, reset, rsp_empty && !req_full)
   `TCG_ASSERT_NEXT(a_last_queued, clock, reset, req_accept && req_payload.last_byte, !mid_empty)
   `TCG_ASSERT_IMPL(a_pop_nonempty, clock, reset, mid_pop, !mid_empty)

endmodule
